FILE: rtl/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants for the touch chord debouncer
// Field widths, function codes, register indexes and per-button state.
// ----------------------------------------------------------------------------
package tcd_pkg;

  localparam int LANES      = 8;
  localparam int RD_W       = 8;
  localparam int CNT_W      = 3;
  localparam int HELD_W     = 4;
  localparam int FUNC_W     = 2;
  localparam int READ_W     = LANES * RD_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_CLEAR = 2'd0;
  localparam func_t FUNC_CAL   = 2'd1;
  localparam func_t FUNC_SCAN  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LIMIT = 1'd0;
  localparam cfg_idx_t CFG_FLOOR = 1'd1;

  localparam logic [CNT_W-1:0] LIMIT_RST = 3'd5;
  localparam logic [RD_W-1:0]  FLOOR_RST = 8'd5;

  typedef struct packed {
    logic [RD_W-1:0]  thr;
    logic [CNT_W-1:0] cnt;
    logic             deb;
  } lane_state_t;

  function automatic logic [HELD_W-1:0] popcount8(input logic [LANES-1:0] v);
    logic [HELD_W-1:0] n;
    n = '0;
    for (int i = 0; i < LANES; i++) begin
      n = n + HELD_W'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: rtl/tcd_in_if.sv
// ----------------------------------------------------------------------------
// tcd_in_if: sample channel
// One beat carries a function code and eight packed sensor readings.
// ----------------------------------------------------------------------------
interface tcd_in_if;
  import tcd_pkg::*;

  logic              valid;
  logic              ready;
  func_t             func;
  logic [READ_W-1:0] readings;

  modport source (output valid, output func, output readings, input ready);
  modport sink   (input valid, input func, input readings, output ready);
endinterface

FILE: rtl/tcd_out_if.sv
// ----------------------------------------------------------------------------
// tcd_out_if: result channel
// One beat per sample: finished chord, held count and debounced mask.
// ----------------------------------------------------------------------------
interface tcd_out_if;
  import tcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [LANES-1:0]  chord_code;
  logic [HELD_W-1:0] keys_held;
  logic [LANES-1:0]  pressed_mask;

  modport source (output valid, output chord_code, output keys_held, output pressed_mask,
                  input ready);
  modport sink   (input valid, input chord_code, input keys_held, input pressed_mask,
                  output ready);
endinterface

FILE: rtl/tcd_lane.sv
// ----------------------------------------------------------------------------
// tcd_lane: per-button next-state logic
// Threshold load/calibration, touch compare and mismatch debounce counter.
// ----------------------------------------------------------------------------
module tcd_lane (
  input  tcd_pkg::func_t             func,
  input  logic [tcd_pkg::RD_W-1:0]   reading,
  input  logic [tcd_pkg::CNT_W-1:0]  limit,
  input  logic [tcd_pkg::RD_W-1:0]   floor_val,
  input  tcd_pkg::lane_state_t       cur,
  output tcd_pkg::lane_state_t       nxt
);
  import tcd_pkg::*;

  logic             touched;
  logic [CNT_W-1:0] cnt_inc;

  assign touched = reading > cur.thr;
  assign cnt_inc = cur.cnt + CNT_W'(1);

  always_comb begin
    nxt = cur;
    unique case (func)
      FUNC_CLEAR: begin
        nxt.thr = floor_val;
        nxt.cnt = '0;
        nxt.deb = 1'b0;
      end
      FUNC_CAL: begin
        if (touched) nxt.thr = reading;
      end
      FUNC_SCAN: begin
        if (touched != cur.deb) begin
          // counter at or past the limit: the mismatch only rearms it
          if (cur.cnt >= limit) begin
            nxt.cnt = '0;
          end else begin
            nxt.cnt = cnt_inc;
            if (cnt_inc == limit) nxt.deb = touched;
          end
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

FILE: rtl/touch_chord_debouncer_core.sv
// ----------------------------------------------------------------------------
// touch_chord_debouncer_core: capacitive touch chord keyer with debounce
// Per-button thresholds and debounce, chord assembly, one result per sample.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock and returns exactly one result beat for it.
// The input register takes the beat when it is accepted and the result
// register takes the processed beat when the result side has room, so a
// result is offered only once its sample has passed both registers.
// All per-button work (threshold compare, mismatch counter, flip) runs in
// parallel lanes in the single stage between the two registers, so the
// sustained rate is one beat per cycle whenever the result side keeps taking
// beats. Buttons at index BUTTONS and above are not built and read as zero.
// No clearing pass is needed after reset.
module touch_chord_debouncer_core #(
  parameter int BUTTONS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  tcd_pkg::cfg_idx_t             cfg_index,
  input  logic [tcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tcd_in_if.sink                        in_ch,
  tcd_out_if.source                     out_ch
);
  import tcd_pkg::*;

  // configuration
  logic [CNT_W-1:0] limit_r;
  logic [RD_W-1:0]  floor_r;

  // input register
  logic              in_valid_r;
  func_t             func_r;
  logic [READ_W-1:0] readings_r;

  // result register
  logic              out_valid_r;
  logic [LANES-1:0]  chord_r;
  logic [HELD_W-1:0] held_r;
  logic [LANES-1:0]  mask_r;

  // block state
  lane_state_t      lane_r   [BUTTONS];
  lane_state_t      lane_nxt [BUTTONS];
  logic [LANES-1:0] stroke_r;
  logic [LANES-1:0] stroke_nxt;

  logic              adv;
  logic              in_ready;
  logic [LANES-1:0]  deb_cur;
  logic [LANES-1:0]  deb_nxt;
  logic [LANES-1:0]  press;
  logic [LANES-1:0]  stroke_acc;
  logic [HELD_W-1:0] held_nxt;
  logic [LANES-1:0]  chord_nxt;

  assign adv      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || adv;

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.chord_code   = chord_r;
  assign out_ch.keys_held    = held_r;
  assign out_ch.pressed_mask = mask_r;

  for (genvar k = 0; k < BUTTONS; k++) begin : g_lane
    tcd_lane u_lane (
      .func      (func_r),
      .reading   (readings_r[RD_W*k +: RD_W]),
      .limit     (limit_r),
      .floor_val (floor_r),
      .cur       (lane_r[k]),
      .nxt       (lane_nxt[k])
    );
  end

  always_comb begin
    deb_cur = '0;
    deb_nxt = '0;
    for (int k = 0; k < BUTTONS; k++) begin
      deb_cur[k] = lane_r[k].deb;
      deb_nxt[k] = lane_nxt[k].deb;
    end
  end

  assign press      = deb_nxt & ~deb_cur;
  assign stroke_acc = stroke_r | press;
  assign held_nxt   = popcount8(deb_nxt);

  always_comb begin
    chord_nxt  = '0;
    stroke_nxt = stroke_r;
    case (func_r)
      FUNC_CLEAR: stroke_nxt = '0;
      FUNC_SCAN: begin
        // chord completes once every key is released
        if (held_nxt == '0) begin
          chord_nxt  = stroke_acc;
          stroke_nxt = '0;
        end else begin
          stroke_nxt = stroke_acc;
        end
      end
      default: stroke_nxt = stroke_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RST;
      floor_r     <= FLOOR_RST;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      stroke_r    <= '0;
      for (int k = 0; k < BUTTONS; k++) begin
        lane_r[k] <= '{thr: FLOOR_RST, cnt: '0, deb: 1'b0};
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LIMIT: limit_r <= cfg_wdata[CNT_W-1:0];
          CFG_FLOOR: floor_r <= cfg_wdata[RD_W-1:0];
          default:   limit_r <= limit_r;
        endcase
      end
      if (in_ready) in_valid_r <= in_ch.valid;
      if (adv) begin
        out_valid_r <= 1'b1;
        stroke_r    <= stroke_nxt;
        for (int k = 0; k < BUTTONS; k++) begin
          lane_r[k] <= lane_nxt[k];
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      func_r     <= in_ch.func;
      readings_r <= in_ch.readings;
    end
    if (adv) begin
      chord_r <= chord_nxt;
      held_r  <= held_nxt;
      mask_r  <= deb_nxt;
    end
  end

`ifndef SYNTHESIS
  a_held_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> held_r == HELD_W'($countones(mask_r)))
    else $error("keys_held disagrees with pressed_mask");

  a_chord_only_when_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && chord_r != '0) |-> (held_r == '0 && mask_r == '0))
    else $error("chord emitted while keys held");

  a_held_in_stroke: assert property (@(posedge clk) disable iff (!rst_n)
    (deb_cur & ~stroke_r) == '0)
    else $error("pressed button missing from stroke");

  a_unused_lanes_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((mask_r >> BUTTONS) == '0 && (chord_r >> BUTTONS) == '0))
    else $error("unbuilt button reported");

  a_result_follows_sample: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed sample produced no result beat");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for touch_chord_debouncer_core
// Drives sample beats through the input channel, predicts each result beat
// from a cycle-free model of thresholds, debounce counters and chord
// assembly, and checks every result beat field by field against it.
// ----------------------------------------------------------------------------
module testbench;
  import tcd_pkg::*;

  // selector value the block does not use: must change nothing
  localparam func_t FUNC_NONE = 2'd3;

  typedef struct packed {
    func_t             func;
    logic [READ_W-1:0] readings;
  } sample_t;

  typedef struct packed {
    logic [LANES-1:0]  chord;
    logic [HELD_W-1:0] held;
    logic [LANES-1:0]  mask;
  } report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcd_in_if  sample_ch ();
  tcd_out_if result_ch ();

  touch_chord_debouncer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (sample_ch),
    .out_ch    (result_ch)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // shadow of the block's registers and per-button state
  logic [CNT_W-1:0]  limit_shadow;
  logic [RD_W-1:0]   floor_shadow;
  logic [RD_W-1:0]   thr        [LANES];
  logic [CNT_W-1:0]  miss_cnt   [LANES];
  logic [LANES-1:0]  deb_bits;
  logic [LANES-1:0]  stroke_bits;
  logic [HELD_W-1:0] held_keys;

  // thresholds as the stimulus will have left them, used to aim readings
  logic [RD_W-1:0]   aim_thr    [LANES];

  sample_t pending_samples [$];
  report_t expected_reports [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches = 0;
  int queued_samples;
  int hold_left;
  bit hold_request;
  bit hold_done;

  function automatic void clear_lanes();
    for (int k = 0; k < LANES; k++) begin
      thr[k]      = floor_shadow;
      miss_cnt[k] = '0;
    end
    deb_bits    = '0;
    stroke_bits = '0;
    held_keys   = '0;
  endfunction

  function automatic report_t debounce_step(sample_t s);
    report_t        rep;
    logic [RD_W-1:0] r;
    logic           touched;
    rep.chord = '0;
    case (s.func)
      FUNC_CLEAR: clear_lanes();
      FUNC_CAL: begin
        for (int k = 0; k < LANES; k++) begin
          r = s.readings[k*RD_W +: RD_W];
          if (r > thr[k]) thr[k] = r;
        end
      end
      FUNC_SCAN: begin
        for (int k = 0; k < LANES; k++) begin
          r       = s.readings[k*RD_W +: RD_W];
          touched = (r > thr[k]);
          // agreement leaves the counter alone
          if (touched != deb_bits[k]) begin
            if (miss_cnt[k] >= limit_shadow) begin
              miss_cnt[k] = '0;
            end else begin
              miss_cnt[k] = miss_cnt[k] + 1'b1;
              if (miss_cnt[k] == limit_shadow) begin
                deb_bits[k] = touched;
                if (touched) begin
                  stroke_bits[k] = 1'b1;
                  held_keys      = held_keys + 1'b1;
                end else begin
                  held_keys = held_keys - 1'b1;
                end
              end
            end
          end
        end
        if (held_keys == '0) begin
          rep.chord   = stroke_bits;
          stroke_bits = '0;
        end
      end
      default: ;
    endcase
    rep.held = held_keys;
    rep.mask = deb_bits;
    return rep;
  endfunction

  task automatic queue_sample(func_t f, logic [READ_W-1:0] rd);
    sample_t s;
    s.func     = f;
    s.readings = rd;
    if (f == FUNC_CLEAR) begin
      for (int k = 0; k < LANES; k++) aim_thr[k] = floor_shadow;
    end else if (f == FUNC_CAL) begin
      for (int k = 0; k < LANES; k++)
        if (rd[k*RD_W +: RD_W] > aim_thr[k]) aim_thr[k] = rd[k*RD_W +: RD_W];
    end
    pending_samples.push_back(s);
    queued_samples++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LIMIT) limit_shadow = v[CNT_W-1:0];
    else floor_shadow = v;
  endtask

  // wait until every queued beat is in and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (!rst_n) begin
      sample_ch.valid    <= 1'b0;
      sample_ch.func     <= FUNC_CLEAR;
      sample_ch.readings <= '0;
      clear_lanes();
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        nxt.func     = sample_ch.func;
        nxt.readings = sample_ch.readings;
        expected_reports.push_back(debounce_step(nxt));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          sample_ch.valid    <= 1'b1;
          sample_ch.func     <= nxt.func;
          sample_ch.readings <= nxt.readings;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, so the block backs up onto its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : check_results
    report_t want;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: chord %h held %0d mask %h",
                     result_ch.chord_code, result_ch.keys_held, result_ch.pressed_mask);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (result_ch.chord_code !== want.chord || result_ch.keys_held !== want.held ||
              result_ch.pressed_mask !== want.mask) begin
            if (mismatches < 10)
              $display("result mismatch: chord %h/%h held %0d/%0d mask %h/%h (exp/act)",
                       want.chord, result_ch.chord_code, want.held, result_ch.keys_held,
                       want.mask, result_ch.pressed_mask);
            mismatches++;
          end
        end
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    logic [READ_W-1:0] rd;
    logic [LANES-1:0]  chord_mask;
    logic              touched_now;
    int                start_t [LANES];
    int                stop_t  [LANES];
    int                len;
    int                span;
    int                lim_eff;
    int                pick;
    int                target;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_LIMIT;
    cfg_wdata          = '0;
    send_idle_pct      = 17;
    recv_idle_pct      = 47;
    queued_samples     = 0;
    hold_request       = 1'b0;
    limit_shadow       = LIMIT_RST;
    floor_shadow       = FLOOR_RST;
    for (int k = 0; k < LANES; k++) aim_thr[k] = FLOOR_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unused selector, full press of all eight, release too short to finish
    queue_sample(FUNC_NONE, {$urandom, $urandom});
    repeat (5) queue_sample(FUNC_SCAN, '1);
    repeat (5) queue_sample(FUNC_SCAN, '0);
    drain();

    // top threshold: nothing can ever read as touched
    write_reg(CFG_LIMIT, 8'd7);
    write_reg(CFG_FLOOR, 8'd255);
    queue_sample(FUNC_CLEAR, '0);
    queue_sample(FUNC_CAL, 64'h00FF_00FF_00FF_00FF);
    queue_sample(FUNC_SCAN, '1);
    drain();

    // zero limit: mismatches only ever clear the counter
    write_reg(CFG_LIMIT, 8'd0);
    write_reg(CFG_FLOOR, 8'd0);
    queue_sample(FUNC_CLEAR, '1);
    repeat (2) queue_sample(FUNC_SCAN, 64'h0101_0101_0101_0101);
    drain();

    // build a count on button 0, then drop the limit beneath it
    write_reg(CFG_LIMIT, 8'd5);
    write_reg(CFG_FLOOR, 8'd5);
    queue_sample(FUNC_CLEAR, '0);
    queue_sample(FUNC_CAL, 64'hA5A5_A5A5_A5A5_A5A5);
    repeat (3) queue_sample(FUNC_SCAN, 64'hFF);
    drain();
    write_reg(CFG_LIMIT, 8'd2);
    repeat (3) queue_sample(FUNC_SCAN, 64'hFF);
    repeat (3) queue_sample(FUNC_SCAN, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 17; recv_idle_pct = 47; end
        1: begin send_idle_pct = 47; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: begin write_reg(CFG_LIMIT, 8'd3); write_reg(CFG_FLOOR, 8'd20);  end
        1: begin write_reg(CFG_LIMIT, 8'd1); write_reg(CFG_FLOOR, 8'd0);   end
        2: begin write_reg(CFG_LIMIT, 8'd7); write_reg(CFG_FLOOR, 8'd60);  end
        3: begin write_reg(CFG_LIMIT, 8'd0); write_reg(CFG_FLOOR, 8'd10);  end
        4: begin write_reg(CFG_LIMIT, 8'd2); write_reg(CFG_FLOOR, 8'd200); end
        default: begin write_reg(CFG_LIMIT, 8'd6); write_reg(CFG_FLOOR, 8'd90); end
      endcase
      if (phase == 4) hold_request = 1'b1;

      target = queued_samples + 210;
      while (queued_samples < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // a chord gesture: optional recalibration, overlapping presses, noise
          if ($urandom_range(2) == 0) begin
            queue_sample(FUNC_CLEAR, {$urandom, $urandom});
            repeat ($urandom_range(4, 1)) begin
              for (int k = 0; k < LANES; k++)
                rd[k*RD_W +: RD_W] = RD_W'($urandom_range(90));
              queue_sample(FUNC_CAL, rd);
            end
          end
          chord_mask = LANES'($urandom_range(255, 1));
          lim_eff    = (limit_shadow == 0) ? 1 : limit_shadow;
          len        = $urandom_range(24, 8);
          for (int k = 0; k < LANES; k++) begin
            start_t[k] = $urandom_range(len / 2);
            stop_t[k]  = start_t[k] + lim_eff + $urandom_range(len / 2);
          end
          // release may first spend a beat clearing a stale count
          span = len + lim_eff + 2 * lim_eff + 3;
          for (int t = 0; t < span; t++) begin
            for (int k = 0; k < LANES; k++) begin
              touched_now = chord_mask[k] && t >= start_t[k] && t < stop_t[k];
              if ($urandom_range(19) == 0) touched_now = !touched_now;
              if (touched_now && aim_thr[k] != 8'hFF)
                rd[k*RD_W +: RD_W] = RD_W'($urandom_range(255, aim_thr[k] + 1));
              else
                rd[k*RD_W +: RD_W] = RD_W'($urandom_range(aim_thr[k], 0));
            end
            queue_sample(FUNC_SCAN, rd);
          end
        end else if (pick < 88) begin
          repeat ($urandom_range(6, 1)) queue_sample(FUNC_SCAN, {$urandom, $urandom});
        end else begin
          queue_sample(func_t'($urandom_range(3)), {$urandom, $urandom});
        end
      end
      drain();
    end

    // let any stray beat out before judging
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(8 * 300000);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcd_pkg.sv
rtl/tcd_in_if.sv
rtl/tcd_out_if.sv
rtl/tcd_lane.sv
rtl/touch_chord_debouncer_core.sv
bench/testbench.sv
